// ----- hdl/mlet_pkg.sv -----
// Shared types and constants for the max line envelope tree.
package mlet_pkg;

   localparam int X_W    = 32;
   localparam int A_W    = 32;
   localparam int B_W    = 61;
   localparam int V_W    = 64;
   localparam int CSR_IDX_W = 8;

   localparam logic [CSR_IDX_W-1:0] REG_RANGE_LOW  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_RANGE_HIGH = CSR_IDX_W'(1);

   localparam logic signed [X_W-1:0] RANGE_LOW_RST  = 32'sh8000_0000;
   localparam logic signed [X_W-1:0] RANGE_HIGH_RST = 32'sh7fff_ffff;

   localparam logic signed [B_W-1:0] EMPTY_B = -61'sd1000000000000000000;
   localparam logic signed [V_W-1:0] EMPTY_V = -64'sd1000000000000000000;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_QUERY  = 1'b1;

   // line evaluations: which line at which x
   typedef enum logic [2:0] {
      EV_NEW_L = 3'd0,
      EV_OLD_L = 3'd1,
      EV_NEW_R = 3'd2,
      EV_OLD_R = 3'd3,
      EV_NEW_M = 3'd4,
      EV_OLD_M = 3'd5,
      EV_OLD_Q = 3'd6
   } ev_type;

   localparam int EV_COUNT = 7;

   typedef struct packed {
      logic   cfg_wr;
      logic   init_root;
      logic   take_item;
      logic   rd_en;
      logic   load_en;
      logic   mul_en;
      ev_type ev;
      logic   ins_step;
      logic   qry_step;
      logic   alloc;
      logic   link;
   } cmd_type;

   typedef struct packed {
      logic mode;
      logic ins_done;
      logic child_zero;
      logic pool_full;
      logic q_last;
   } stat_type;

endpackage

// ----- hdl/mlet_if.sv -----
// Handshake channels for items, results and register writes.
interface mlet_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   mode;
   logic signed [mlet_pkg::A_W-1:0]        slope;
   logic signed [mlet_pkg::B_W-1:0]        intercept;
   logic signed [mlet_pkg::X_W-1:0]        query_x;
   modport source (output valid, mode, slope, intercept, query_x, input ready);
   modport sink   (input valid, mode, slope, intercept, query_x, output ready);
endinterface

interface mlet_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [mlet_pkg::V_W-1:0]        best_value;
   logic                                   pool_full;
   modport source (output valid, best_value, pool_full, input ready);
   modport sink   (input valid, best_value, pool_full, output ready);
endinterface

interface mlet_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [mlet_pkg::CSR_IDX_W-1:0]         index;
   logic [31:0]                            data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/max_line_envelope_tree_top.sv -----
// Top level of the max line envelope tree: controller, datapath and assertions.
// Per visited node the walk reads the node, loads the midpoint, evaluates the lines, drains and
// decides; an insert may also allocate and link a new child. One item at a time: a new item is
// taken only in idle, after the last result is taken; the single node read port and shared multiplier
// serve each visited node in turn. Reset, and a write of either range register, rebuild the root.
module max_line_envelope_tree_top #(
   parameter int POOL_NODES = 4096
) (
   input  logic       clock,
   input  logic       reset,
   mlet_req_if.sink   req_ch,
   mlet_rsp_if.source rsp_ch,
   mlet_csr_if.sink   csr_ch
);
   mlet_pkg::cmd_type  cmd;
   mlet_pkg::stat_type stat;

   mlet_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .csr_valid (csr_ch.valid),
      .csr_ready (csr_ch.ready),
      .csr_index (csr_ch.index),
      .stat      (stat),
      .cmd       (cmd)
   );

   mlet_dp #(.POOL_NODES(POOL_NODES)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .csr_index      (csr_ch.index),
      .csr_data       (csr_ch.data),
      .item_mode      (req_ch.mode),
      .item_slope     (req_ch.slope),
      .item_intercept (req_ch.intercept),
      .item_query_x   (req_ch.query_x),
      .best_value     (rsp_ch.best_value),
      .pool_full      (rsp_ch.pool_full)
   );

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (!req_ch.ready && !rsp_ch.valid))
      else $error("item taken while a walk was in progress");

   a_rsp_drops: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready) |=> (!rsp_ch.valid && csr_ch.ready))
      else $error("result repeated after it was taken");

   a_query_not_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.pool_full) |-> (rsp_ch.best_value == '0))
      else $error("pool full flagged on a query result");

endmodule

// ----- hdl/mlet_dp.sv -----
// Datapath: node pool memories, shared line evaluator and walk registers.
module mlet_dp #(
   parameter int POOL_NODES = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mlet_pkg::cmd_type                  cmd,
   output mlet_pkg::stat_type                 stat,
   input  logic [mlet_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                        csr_data,
   input  logic                               item_mode,
   input  logic signed [mlet_pkg::A_W-1:0]    item_slope,
   input  logic signed [mlet_pkg::B_W-1:0]    item_intercept,
   input  logic signed [mlet_pkg::X_W-1:0]    item_query_x,
   output logic signed [mlet_pkg::V_W-1:0]    best_value,
   output logic                               pool_full
);
   localparam int AW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
   localparam int CW = $clog2(POOL_NODES + 1);

   logic [AW-1:0]                       mem_lc [POOL_NODES];
   logic [AW-1:0]                       mem_rc [POOL_NODES];
   logic signed [mlet_pkg::X_W-1:0]     mem_lo [POOL_NODES];
   logic signed [mlet_pkg::X_W-1:0]     mem_hi [POOL_NODES];
   logic signed [mlet_pkg::A_W-1:0]     mem_a  [POOL_NODES];
   logic signed [mlet_pkg::B_W-1:0]     mem_b  [POOL_NODES];

   logic signed [mlet_pkg::X_W-1:0] range_low_ff, range_high_ff;
   logic [CW-1:0]                   used_ff;
   logic [AW-1:0]                   node_ff, new_ff;
   logic                            mode_ff, full_ff, right_ff;
   logic signed [mlet_pkg::A_W-1:0] cur_a_ff, ln_a_ff;
   logic signed [mlet_pkg::B_W-1:0] cur_b_ff, ln_b_ff, b_ff;
   logic signed [mlet_pkg::X_W-1:0] qx_ff, lo_ff, hi_ff, mid_ff;
   logic [AW-1:0]                   lc_ff, rc_ff;
   logic signed [mlet_pkg::V_W-1:0] prod_ff, best_ff;
   logic signed [mlet_pkg::V_W-1:0] val_ff [mlet_pkg::EV_COUNT];
   mlet_pkg::ev_type                ev_ff;
   logic                            add_ff;

   logic signed [mlet_pkg::A_W-1:0] mul_a;
   logic signed [mlet_pkg::X_W-1:0] mul_x;
   logic signed [mlet_pkg::B_W-1:0] mul_b;
   logic signed [mlet_pkg::X_W:0]   mid_sum, mid_rnd;
   logic                            swap, done, go_right, q_left;
   logic signed [mlet_pkg::V_W-1:0] lo_r, hi_r, lo_m, hi_m, qv;
   logic signed [mlet_pkg::A_W-1:0] hi_a, lo_a, keep_a, carry_a;
   logic signed [mlet_pkg::B_W-1:0] hi_b, lo_b, keep_b, carry_b;
   logic [AW-1:0]                   child, q_next;

   always_comb begin
      case (cmd.ev)
         mlet_pkg::EV_NEW_L: begin mul_a = cur_a_ff; mul_x = lo_ff;  mul_b = cur_b_ff; end
         mlet_pkg::EV_OLD_L: begin mul_a = ln_a_ff;  mul_x = lo_ff;  mul_b = ln_b_ff;  end
         mlet_pkg::EV_NEW_R: begin mul_a = cur_a_ff; mul_x = hi_ff;  mul_b = cur_b_ff; end
         mlet_pkg::EV_OLD_R: begin mul_a = ln_a_ff;  mul_x = hi_ff;  mul_b = ln_b_ff;  end
         mlet_pkg::EV_NEW_M: begin mul_a = cur_a_ff; mul_x = mid_ff; mul_b = cur_b_ff; end
         mlet_pkg::EV_OLD_M: begin mul_a = ln_a_ff;  mul_x = mid_ff; mul_b = ln_b_ff;  end
         default: begin mul_a = ln_a_ff; mul_x = qx_ff; mul_b = ln_b_ff; end
      endcase
   end

   assign mid_sum = {lo_ff[mlet_pkg::X_W-1], lo_ff} + {hi_ff[mlet_pkg::X_W-1], hi_ff};
   assign mid_rnd = mid_sum + {{mlet_pkg::X_W{1'b0}}, mid_sum[mlet_pkg::X_W]};

   assign swap   = val_ff[mlet_pkg::EV_NEW_L] > val_ff[mlet_pkg::EV_OLD_L];
   assign lo_r   = swap ? val_ff[mlet_pkg::EV_OLD_R] : val_ff[mlet_pkg::EV_NEW_R];
   assign hi_r   = swap ? val_ff[mlet_pkg::EV_NEW_R] : val_ff[mlet_pkg::EV_OLD_R];
   assign lo_m   = swap ? val_ff[mlet_pkg::EV_OLD_M] : val_ff[mlet_pkg::EV_NEW_M];
   assign hi_m   = swap ? val_ff[mlet_pkg::EV_NEW_M] : val_ff[mlet_pkg::EV_OLD_M];
   assign hi_a   = swap ? cur_a_ff : ln_a_ff;
   assign hi_b   = swap ? cur_b_ff : ln_b_ff;
   assign lo_a   = swap ? ln_a_ff : cur_a_ff;
   assign lo_b   = swap ? ln_b_ff : cur_b_ff;
   assign done   = lo_r <= hi_r;
   assign go_right = lo_m < hi_m;
   assign keep_a  = (done || go_right) ? hi_a : lo_a;
   assign keep_b  = (done || go_right) ? hi_b : lo_b;
   assign carry_a = go_right ? lo_a : hi_a;
   assign carry_b = go_right ? lo_b : hi_b;
   assign child   = go_right ? rc_ff : lc_ff;

   assign qv     = val_ff[mlet_pkg::EV_OLD_Q];
   assign q_left = qx_ff <= mid_ff;
   assign q_next = q_left ? lc_ff : rc_ff;

   assign stat.mode       = mode_ff;
   assign stat.ins_done   = done;
   assign stat.child_zero = (child == '0);
   assign stat.pool_full  = (used_ff == CW'(POOL_NODES));
   assign stat.q_last     = (q_next == '0);

   assign best_value = (mode_ff == mlet_pkg::MODE_QUERY) ? best_ff : '0;
   assign pool_full  = (mode_ff == mlet_pkg::MODE_INSERT) && full_ff;

   // node pool
   always_ff @(posedge clock) begin
      if (cmd.init_root) begin
         mem_lc[0] <= '0;
         mem_rc[0] <= '0;
         mem_lo[0] <= range_low_ff;
         mem_hi[0] <= range_high_ff;
         mem_a[0]  <= '0;
         mem_b[0]  <= mlet_pkg::EMPTY_B;
      end else if (cmd.alloc) begin
         mem_lc[used_ff[AW-1:0]] <= '0;
         mem_rc[used_ff[AW-1:0]] <= '0;
         mem_lo[used_ff[AW-1:0]] <= right_ff ? mid_ff + 32'sd1 : lo_ff;
         mem_hi[used_ff[AW-1:0]] <= right_ff ? hi_ff : mid_ff;
         mem_a[used_ff[AW-1:0]]  <= '0;
         mem_b[used_ff[AW-1:0]]  <= mlet_pkg::EMPTY_B;
      end else if (cmd.ins_step) begin
         mem_a[node_ff] <= keep_a;
         mem_b[node_ff] <= keep_b;
      end else if (cmd.link) begin
         if (right_ff) begin
            mem_rc[node_ff] <= new_ff;
         end else begin
            mem_lc[node_ff] <= new_ff;
         end
      end
      if (cmd.rd_en) begin
         lc_ff   <= mem_lc[node_ff];
         rc_ff   <= mem_rc[node_ff];
         lo_ff   <= mem_lo[node_ff];
         hi_ff   <= mem_hi[node_ff];
         ln_a_ff <= mem_a[node_ff];
         ln_b_ff <= mem_b[node_ff];
      end
   end

   // evaluator: multiply, then add
   always_ff @(posedge clock) begin
      if (cmd.load_en) begin
         mid_ff <= mid_rnd[mlet_pkg::X_W:1];
      end
      prod_ff <= mlet_pkg::V_W'(mul_a) * mlet_pkg::V_W'(mul_x);
      b_ff    <= mul_b;
      ev_ff   <= cmd.ev;
      if (add_ff) begin
         val_ff[ev_ff] <= prod_ff + {{(mlet_pkg::V_W-mlet_pkg::B_W){b_ff[mlet_pkg::B_W-1]}}, b_ff};
      end
      if (cmd.take_item) begin
         mode_ff  <= item_mode;
         cur_a_ff <= item_slope;
         cur_b_ff <= item_intercept;
         qx_ff    <= item_query_x;
         best_ff  <= mlet_pkg::EMPTY_V;
      end else if (cmd.ins_step) begin
         cur_a_ff <= carry_a;
         cur_b_ff <= carry_b;
         right_ff <= go_right;
      end else if (cmd.qry_step) begin
         if (qv > best_ff) begin
            best_ff <= qv;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= mlet_pkg::RANGE_LOW_RST;
         range_high_ff <= mlet_pkg::RANGE_HIGH_RST;
         used_ff       <= CW'(1);
         node_ff       <= '0;
         new_ff        <= '0;
         full_ff       <= 1'b0;
         add_ff        <= 1'b0;
      end else begin
         add_ff <= cmd.mul_en;
         if (cmd.cfg_wr) begin
            if (csr_index == mlet_pkg::REG_RANGE_LOW) begin
               range_low_ff <= csr_data;
            end
            if (csr_index == mlet_pkg::REG_RANGE_HIGH) begin
               range_high_ff <= csr_data;
            end
         end
         if (cmd.init_root) begin
            used_ff <= CW'(1);
         end
         if (cmd.take_item) begin
            node_ff <= '0;
            full_ff <= 1'b0;
         end
         if (cmd.ins_step && !done) begin
            if (child != '0) begin
               node_ff <= child;
            end else if (used_ff == CW'(POOL_NODES)) begin
               full_ff <= 1'b1;
            end
         end
         if (cmd.qry_step) begin
            node_ff <= q_next;
         end
         if (cmd.alloc) begin
            new_ff  <= used_ff[AW-1:0];
            used_ff <= used_ff + CW'(1);
         end
         if (cmd.link) begin
            node_ff <= new_ff;
         end
      end
   end

endmodule

// ----- hdl/mlet_ctrl.sv -----
// Controller: sequences tree walks, evaluations, allocation and handshakes.
module mlet_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mlet_pkg::CSR_IDX_W-1:0] csr_index,
   input  mlet_pkg::stat_type             stat,
   output mlet_pkg::cmd_type              cmd
);
   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_RD, ST_LOAD, ST_MUL, ST_DRAIN,
      ST_DECIDE, ST_ALLOC, ST_LINK, ST_RESP
   } state_type;

   state_type        state_ff;
   mlet_pkg::ev_type ev_ff;
   logic             ins_mode, cfg_hit;

   assign req_ready = (state_ff == ST_IDLE) && !(csr_valid && cfg_hit);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign ins_mode  = (stat.mode == mlet_pkg::MODE_INSERT);
   assign cfg_hit   = csr_index inside {mlet_pkg::REG_RANGE_LOW, mlet_pkg::REG_RANGE_HIGH};

   always_comb begin
      cmd           = '0;
      cmd.ev        = ev_ff;
      cmd.cfg_wr    = csr_valid && csr_ready;
      cmd.init_root = (state_ff == ST_INIT);
      cmd.take_item = req_valid && req_ready;
      cmd.rd_en     = (state_ff == ST_RD);
      cmd.load_en   = (state_ff == ST_LOAD);
      cmd.mul_en    = (state_ff == ST_MUL);
      cmd.ins_step  = (state_ff == ST_DECIDE) && ins_mode;
      cmd.qry_step  = (state_ff == ST_DECIDE) && !ins_mode;
      cmd.alloc     = (state_ff == ST_ALLOC);
      cmd.link      = (state_ff == ST_LINK);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         ev_ff    <= mlet_pkg::EV_NEW_L;
      end else begin
         case (state_ff)
            ST_INIT: state_ff <= ST_IDLE;
            ST_IDLE: begin
               if (csr_valid && cfg_hit) begin
                  state_ff <= ST_INIT;
               end else if (req_valid) begin
                  state_ff <= ST_RD;
               end
            end
            ST_RD: state_ff <= ST_LOAD;
            ST_LOAD: begin
               ev_ff    <= ins_mode ? mlet_pkg::EV_NEW_L : mlet_pkg::EV_OLD_Q;
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               if (!ins_mode || ev_ff == mlet_pkg::EV_OLD_M) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  ev_ff <= mlet_pkg::ev_type'(ev_ff + 3'd1);
               end
            end
            ST_DRAIN: state_ff <= ST_DECIDE;
            ST_DECIDE: begin
               if (!ins_mode) begin
                  state_ff <= stat.q_last ? ST_RESP : ST_RD;
               end else if (stat.ins_done) begin
                  state_ff <= ST_RESP;
               end else if (!stat.child_zero) begin
                  state_ff <= ST_RD;
               end else if (stat.pool_full) begin
                  state_ff <= ST_RESP;
               end else begin
                  state_ff <= ST_ALLOC;
               end
            end
            ST_ALLOC: state_ff <= ST_LINK;
            ST_LINK:  state_ff <= ST_RD;
            ST_RESP: begin
               if (rsp_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_INIT;
         endcase
      end
   end

endmodule
